// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge once reset is released.
`define ASSERT_CLK(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
		else $error("%m: check failed");

// Same check with a caller-supplied message.
`define ASSERT_CLK_MSG(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
		else $error(msg);

`endif

// ===== sv/bmhem_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmhem_pkg
// Types, codes and helpers shared by the bounded max-heap blocks.
// ----------------------------------------------------------------------------
package bmhem_pkg;

	localparam int KEY_W     = 32;
	localparam int HDL_W     = 16;
	localparam int FILL_W    = 11;
	localparam int ENTRY_W   = KEY_W + HDL_W;
	localparam int DEPTH_DEF = 1024;

	localparam logic [FILL_W-1:0] CAP_RESET = 11'd1024;

	localparam logic [1:0] OP_PUSH  = 2'd0;
	localparam logic [1:0] OP_PPUSH = 2'd1;
	localparam logic [1:0] OP_POP   = 2'd2;
	localparam logic [1:0] OP_CLEAR = 2'd3;

	localparam logic [1:0] ST_DONE      = 2'd0;
	localparam logic [1:0] ST_REJECT    = 2'd1;
	localparam logic [1:0] ST_POP_EMPTY = 2'd2;

	localparam logic REG_CAPACITY = 1'b0;

	typedef struct packed {
		logic [1:0]              opcode;
		logic signed [KEY_W-1:0] item_key;
		logic [HDL_W-1:0]        item_handle;
	} req_t;

	typedef struct packed {
		logic [1:0]              status;
		logic                    evicted;
		logic signed [KEY_W-1:0] out_key;
		logic [HDL_W-1:0]        out_handle;
		logic [FILL_W-1:0]       fill_count;
		logic                    is_empty;
		logic                    is_full;
	} rsp_t;

	typedef struct packed {
		logic signed [KEY_W-1:0] key;
		logic [HDL_W-1:0]        handle;
	} entry_t;

	function automatic logic key_less(input logic signed [KEY_W-1:0] a,
		input logic signed [KEY_W-1:0] b);
		return a < b;
	endfunction

endpackage

// ===== sv/bmhem_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmhem_ram
// Heap entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bmhem_ram import bmhem_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [$clog2(DEPTH)-1:0]   waddr,
	input  logic [ENTRY_W-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0]   raddr,
	output logic [ENTRY_W-1:0]         rdata
);

	logic [ENTRY_W-1:0] mem [DEPTH];
	logic [ENTRY_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/bounded_max_heap_evict_min_core.sv =====
`timescale 1ns / 1ps
// Sequence: clear and failed pop go straight to the result; pop reads the root and the
// last entry, then sifts the last entry down from the root; push with room inserts
// and sifts up; a push on a full heap, or an OP_PPUSH on a nonempty heap, first scans
// the leaves for the minimum and, on eviction, refills the hole and sifts the moved leaf.
// Throughput: one request at a time, set by the single read port of the entry RAM.
// Reset: fill count zero, capacity 1024, no result pending; RAM is not cleared.
// ----------------------------------------------------------------------------
// bounded_max_heap_evict_min_core
// Bounded binary max-heap of (key, handle) with min-leaf eviction when full.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bounded_max_heap_evict_min_core import bmhem_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// request channel
	input  logic        in_valid,
	output logic        in_ready,
	input  req_t        in_req,
	// result channel
	output logic        out_valid,
	input  logic        out_ready,
	output rsp_t        out_rsp,
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	// sequencer states
	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_SCAN     = 4'd1;
	localparam logic [3:0] S_SCAN_END = 4'd2;
	localparam logic [3:0] S_DECIDE   = 4'd3;
	localparam logic [3:0] S_EV_RD    = 4'd4;
	localparam logic [3:0] S_EV_D     = 4'd5;
	localparam logic [3:0] S_INS      = 4'd6;
	localparam logic [3:0] S_UP_RD    = 4'd7;
	localparam logic [3:0] S_UP_CMP   = 4'd8;
	localparam logic [3:0] S_ROOT_RD  = 4'd9;
	localparam logic [3:0] S_ROOT_D   = 4'd10;
	localparam logic [3:0] S_LAST_D   = 4'd11;
	localparam logic [3:0] S_DN_L     = 4'd12;
	localparam logic [3:0] S_DN_R     = 4'd13;
	localparam logic [3:0] S_DN_C     = 4'd14;
	localparam logic [3:0] S_DONE     = 4'd15;

	logic [3:0]        state_q;
	logic [FILL_W-1:0] cap_q;
	logic [CW-1:0]     cnt_q;
	logic [1:0]        op_q;
	entry_t            new_q;
	entry_t            cur_q;
	entry_t            min_q;
	entry_t            child_q;
	entry_t            pop_q;
	logic [AW-1:0]     pos_q;
	logic [AW-1:0]     min_idx_q;
	logic [AW-1:0]     scan_idx_q;
	logic [AW-1:0]     cidx_q;
	logic              scan_vld_s1;
	logic [AW-1:0]     scan_idx_s1;
	logic              has_right_q;
	logic              evict_q;
	logic              full_q;
	logic              ins_after_q;
	logic [1:0]        status_q;
	logic              out_valid_q;
	rsp_t              out_rsp_q;

	// RAM ports
	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	logic [ENTRY_W-1:0] ram_wdata;
	logic [AW-1:0]      ram_raddr;
	logic [ENTRY_W-1:0] ram_rdata;
	entry_t             rd_entry;

	logic [31:0]   cap_ext;
	logic [31:0]   eff_ext;
	logic [CW-1:0] eff_cap;
	logic          full_now;
	logic [AW-1:0] half_idx;
	logic [AW-1:0] last_idx;
	logic [AW-1:0] parent_idx;
	logic [CW:0]   j_w;
	logic [CW:0]   jr_w;
	logic          j_ok;
	logic          right_ok;
	logic          up_stop;
	entry_t        dn_sel;
	logic [AW-1:0] dn_sel_idx;
	logic          dn_move;
	logic          pop_ok;
	logic          rsp_load;

	bmhem_ram #(.DEPTH(DEPTH)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign rd_entry = entry_t'(ram_rdata);

	// Effective capacity: zero counts as one, anything past DEPTH as DEPTH.
	assign cap_ext  = 32'(cap_q);
	assign eff_ext  = (cap_ext == 32'd0) ? 32'd1 :
		((cap_ext > 32'(DEPTH)) ? 32'(DEPTH) : cap_ext);
	assign eff_cap  = CW'(eff_ext);
	assign full_now = cnt_q >= eff_cap;

	assign half_idx   = AW'(cnt_q >> 1);
	assign last_idx   = AW'(cnt_q - CW'(1));
	assign parent_idx = AW'((pos_q - AW'(1)) >> 1);
	assign j_w        = (CW+1)'({pos_q, 1'b1});
	assign jr_w       = j_w + (CW+1)'(1);
	assign j_ok       = j_w < (CW+1)'(cnt_q);
	assign right_ok   = jr_w < (CW+1)'(cnt_q);

	// Sift-up stops once the parent is strictly larger; equal keys move up.
	assign up_stop = key_less(cur_q.key, rd_entry.key);

	// Larger child, left on a tie; the right child is in the read register.
	always_comb begin
		if (has_right_q && key_less(child_q.key, rd_entry.key)) begin
			dn_sel     = rd_entry;
			dn_sel_idx = cidx_q + AW'(1);
		end else begin
			dn_sel     = child_q;
			dn_sel_idx = cidx_q;
		end
	end
	assign dn_move = key_less(cur_q.key, dn_sel.key);

	// Memory access per state: the moving entry sits in cur_q and is written only
	// when it settles; each step writes the parent or child that moves into the hole.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = pos_q;
		ram_wdata = ENTRY_W'(cur_q);
		ram_raddr = '0;
		case (state_q)
			S_SCAN: begin
				ram_raddr = scan_idx_q;
			end
			S_EV_RD: begin
				ram_raddr = AW'(cnt_q);
			end
			S_UP_RD: begin
				if (pos_q == '0) begin
					ram_we = 1'b1;
				end else begin
					ram_raddr = parent_idx;
				end
			end
			S_UP_CMP: begin
				ram_we = 1'b1;
				if (!up_stop) begin
					ram_wdata = ENTRY_W'(rd_entry);
				end
			end
			S_ROOT_D: begin
				ram_raddr = last_idx;
			end
			S_DN_L: begin
				if (j_ok) begin
					ram_raddr = AW'(j_w);
				end else begin
					ram_we = 1'b1;
				end
			end
			S_DN_R: begin
				ram_raddr = AW'(jr_w);
			end
			S_DN_C: begin
				ram_we = 1'b1;
				if (dn_move) begin
					ram_wdata = ENTRY_W'(dn_sel);
				end
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	assign pop_ok = (op_q == OP_POP) && (status_q == ST_DONE);

	// Load the result once the output register is free or being drained.
	assign rsp_load = (state_q == S_DONE) && (!out_valid_q || out_ready);

	// Sequencer and working registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			scan_vld_s1 <= 1'b0;
			ins_after_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rsp_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			// Track the running leaf minimum; first index wins ties.
			if (scan_vld_s1) begin
				if (scan_idx_s1 == half_idx || key_less(rd_entry.key, min_q.key)) begin
					min_q     <= rd_entry;
					min_idx_q <= scan_idx_s1;
				end
			end

			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						op_q         <= in_req.opcode;
						new_q.key    <= in_req.item_key;
						new_q.handle <= in_req.item_handle;
						status_q     <= ST_DONE;
						evict_q      <= 1'b0;
						full_q       <= full_now;
						scan_idx_q   <= half_idx;
						case (in_req.opcode)
							OP_CLEAR: begin
								cnt_q   <= '0;
								state_q <= S_DONE;
							end
							OP_POP: begin
								if (cnt_q == '0) begin
									status_q <= ST_POP_EMPTY;
									state_q  <= S_DONE;
								end else begin
									state_q <= S_ROOT_RD;
								end
							end
							OP_PUSH: begin
								state_q <= full_now ? S_SCAN : S_INS;
							end
							default: begin
								state_q <= (cnt_q == '0) ? S_INS : S_SCAN;
							end
						endcase
					end
				end
				S_SCAN: begin
					scan_vld_s1 <= 1'b1;
					scan_idx_s1 <= scan_idx_q;
					if (scan_idx_q == last_idx) begin
						state_q <= S_SCAN_END;
					end else begin
						scan_idx_q <= scan_idx_q + AW'(1);
					end
				end
				S_SCAN_END: begin
					scan_vld_s1 <= 1'b0;
					state_q     <= S_DECIDE;
				end
				S_DECIDE: begin
					if (op_q == OP_PUSH ? key_less(min_q.key, new_q.key)
						: !key_less(new_q.key, min_q.key)) begin
						if (op_q == OP_PUSH || full_q) begin
							evict_q <= 1'b1;
							cnt_q   <= cnt_q - CW'(1);
							state_q <= (min_idx_q == last_idx) ? S_INS : S_EV_RD;
						end else begin
							state_q <= S_INS;
						end
					end else begin
						status_q <= ST_REJECT;
						state_q  <= S_DONE;
					end
				end
				S_EV_RD: begin
					state_q <= S_EV_D;
				end
				S_EV_D: begin
					cur_q       <= rd_entry;
					pos_q       <= min_idx_q;
					ins_after_q <= 1'b1;
					state_q     <= S_UP_RD;
				end
				S_INS: begin
					if (cnt_q == CW'(DEPTH)) begin
						state_q <= S_DONE;
					end else begin
						cur_q   <= new_q;
						pos_q   <= AW'(cnt_q);
						cnt_q   <= cnt_q + CW'(1);
						state_q <= S_UP_RD;
					end
				end
				S_UP_RD: begin
					if (pos_q == '0) begin
						ins_after_q <= 1'b0;
						state_q     <= ins_after_q ? S_INS : S_DONE;
					end else begin
						state_q <= S_UP_CMP;
					end
				end
				S_UP_CMP: begin
					if (up_stop) begin
						ins_after_q <= 1'b0;
						state_q     <= ins_after_q ? S_INS : S_DONE;
					end else begin
						pos_q   <= parent_idx;
						state_q <= S_UP_RD;
					end
				end
				S_ROOT_RD: begin
					state_q <= S_ROOT_D;
				end
				S_ROOT_D: begin
					pop_q   <= rd_entry;
					cnt_q   <= cnt_q - CW'(1);
					state_q <= S_LAST_D;
				end
				S_LAST_D: begin
					cur_q   <= rd_entry;
					pos_q   <= '0;
					state_q <= S_DN_L;
				end
				S_DN_L: begin
					state_q <= j_ok ? S_DN_R : S_DONE;
				end
				S_DN_R: begin
					child_q     <= rd_entry;
					cidx_q      <= AW'(j_w);
					has_right_q <= right_ok;
					state_q     <= S_DN_C;
				end
				S_DN_C: begin
					if (dn_move) begin
						pos_q   <= dn_sel_idx;
						state_q <= S_DN_L;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					// Hold the result until the output register frees up.
					if (rsp_load) begin
						out_rsp_q.status      <= status_q;
						out_rsp_q.evicted     <= evict_q;
						out_rsp_q.out_key     <= pop_ok ? pop_q.key : '0;
						out_rsp_q.out_handle  <= pop_ok ? pop_q.handle : '0;
						out_rsp_q.fill_count  <= FILL_W'(cnt_q);
						out_rsp_q.is_empty    <= (cnt_q == '0);
						out_rsp_q.is_full     <= full_now;
						state_q               <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Capacity register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (psel && penable && pwrite && paddr[2] == REG_CAPACITY) begin
			cap_q <= pwdata[FILL_W-1:0];
		end
	end

	assign prdata    = (paddr[2] == REG_CAPACITY) ? 32'(cap_q) : 32'd0;
	assign pready    = 1'b1;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_rsp   = out_rsp_q;

	`ASSERT_CLK(a_cnt_bound, clk, arst_n, cnt_q <= CW'(DEPTH))
	`ASSERT_CLK(a_accept_starts, clk, arst_n, (in_valid && in_ready) |=> (state_q != S_IDLE))
	`ASSERT_CLK_MSG(a_empty_not_full, clk, arst_n,
		out_valid |-> !(out_rsp.is_empty && out_rsp.is_full), "empty and full together")
	`ASSERT_CLK_MSG(a_pop_empty_zero, clk, arst_n,
		(out_valid && out_rsp.status == ST_POP_EMPTY) |-> (out_rsp.fill_count == '0),
		"failed pop on nonempty heap")

endmodule

// ===== bench/bounded_max_heap_evict_min_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_max_heap_evict_min_core_tb
// Drives random and directed heap requests through the valid/ready channels,
// changes the capacity over APB between phases, and compares every result
// against a behavioral heap kept in a scoreboard class.
// ----------------------------------------------------------------------------
module bounded_max_heap_evict_min_core_tb import bmhem_pkg::*; ();

	localparam int HEAP_DEPTH = DEPTH_DEF;

	// Behavioral heap plus queue of expected results.
	class heap_scoreboard;
		logic signed [KEY_W-1:0] keys[HEAP_DEPTH];
		logic [HDL_W-1:0]        hdls[HEAP_DEPTH];
		int unsigned             fill;
		int unsigned             cap;
		rsp_t                    pending[$];
		int                      errors;

		function new();
			fill = 0;
			cap = 1024;
			errors = 0;
		endfunction

		function int unsigned eff_cap();
			if (cap == 0) return 1;
			if (cap > HEAP_DEPTH) return HEAP_DEPTH;
			return cap;
		endfunction

		function void swap_at(int unsigned a, int unsigned b);
			logic signed [KEY_W-1:0] tk;
			logic [HDL_W-1:0]        th;
			tk = keys[a]; th = hdls[a];
			keys[a] = keys[b]; hdls[a] = hdls[b];
			keys[b] = tk; hdls[b] = th;
		endfunction

		// Move up while the parent key is less than or equal.
		function void rise(int unsigned i);
			int unsigned p;
			while (i > 0) begin
				p = (i - 1) / 2;
				if (keys[i] < keys[p]) break;
				swap_at(i, p);
				i = p;
			end
		endfunction

		function void sink();
			int unsigned i, j;
			i = 0;
			forever begin
				j = 2 * i + 1;
				if (j >= fill) break;
				if (j + 1 < fill && keys[j] < keys[j + 1]) j = j + 1;
				if (!(keys[i] < keys[j])) break;
				swap_at(i, j);
				i = j;
			end
		endfunction

		function int unsigned smallest_leaf();
			int unsigned m, i;
			m = fill / 2;
			for (i = m + 1; i < fill; i++)
				if (keys[i] < keys[m]) m = i;
			return m;
		endfunction

		function void drop_at(int unsigned m);
			fill = fill - 1;
			if (m != fill) begin
				keys[m] = keys[fill];
				hdls[m] = hdls[fill];
				if (fill > 1) rise(m);
			end
		endfunction

		function void insert(logic signed [KEY_W-1:0] k, logic [HDL_W-1:0] h);
			if (fill >= HEAP_DEPTH) return;
			keys[fill] = k;
			hdls[fill] = h;
			fill = fill + 1;
			rise(fill - 1);
		endfunction

		// Note an accepted request and queue its expected result.
		function void note_request(req_t r);
			rsp_t        e;
			int unsigned c, m;
			bit          full;
			c = eff_cap();
			full = fill >= c;
			e = '0;
			case (r.opcode)
				OP_PUSH: begin
					if (full) begin
						m = smallest_leaf();
						if (keys[m] < r.item_key) begin
							drop_at(m);
							e.evicted = 1'b1;
							insert(r.item_key, r.item_handle);
						end else e.status = ST_REJECT;
					end else insert(r.item_key, r.item_handle);
				end
				OP_PPUSH: begin
					if (fill == 0) insert(r.item_key, r.item_handle);
					else begin
						m = smallest_leaf();
						if (!(r.item_key < keys[m])) begin
							if (full) begin
								drop_at(m);
								e.evicted = 1'b1;
							end
							insert(r.item_key, r.item_handle);
						end else e.status = ST_REJECT;
					end
				end
				OP_POP: begin
					if (fill == 0) e.status = ST_POP_EMPTY;
					else begin
						e.out_key = keys[0];
						e.out_handle = hdls[0];
						fill = fill - 1;
						keys[0] = keys[fill];
						hdls[0] = hdls[fill];
						if (fill > 1) sink();
					end
				end
				default: fill = 0;
			endcase
			e.fill_count = fill[FILL_W-1:0];
			e.is_empty = fill == 0;
			e.is_full = fill >= c;
			pending.push_back(e);
		endfunction

		// Compare one result against the oldest expectation.
		function void check_result(rsp_t a);
			rsp_t e;
			if (pending.size() == 0) begin
				$error("result with nothing expected: %p", a);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (a.status !== e.status) begin
				$error("status exp %0d got %0d", e.status, a.status); errors++;
			end
			if (a.evicted !== e.evicted) begin
				$error("evicted exp %0d got %0d", e.evicted, a.evicted); errors++;
			end
			if (a.out_key !== e.out_key) begin
				$error("out_key exp %0d got %0d", e.out_key, a.out_key); errors++;
			end
			if (a.out_handle !== e.out_handle) begin
				$error("out_handle exp %0d got %0d", e.out_handle, a.out_handle);
				errors++;
			end
			if (a.fill_count !== e.fill_count) begin
				$error("fill_count exp %0d got %0d", e.fill_count, a.fill_count);
				errors++;
			end
			if (a.is_empty !== e.is_empty) begin
				$error("is_empty exp %0d got %0d", e.is_empty, a.is_empty); errors++;
			end
			if (a.is_full !== e.is_full) begin
				$error("is_full exp %0d got %0d", e.is_full, a.is_full); errors++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	req_t        in_req = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	rsp_t        out_rsp;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	heap_scoreboard heap_model = new();
	int send_idle_pct = 0;
	int recv_idle_pct = 0;

	always #4 clk = ~clk;

	bounded_max_heap_evict_min_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_req(in_req),
		.out_valid(out_valid), .out_ready(out_ready), .out_rsp(out_rsp),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// Check results at the rising edge; change ready at the falling edge.
	always @(posedge clk)
		if (arst_n && out_valid && out_ready) heap_model.check_result(out_rsp);

	always @(negedge clk)
		out_ready <= ($urandom_range(99) >= recv_idle_pct);

	// Hold one request until accepted, with random idle cycles ahead of it.
	// Return at the falling edge after acceptance; valid drops on the next
	// idle cycle or in drain.
	task automatic send_request(logic [1:0] op, logic signed [KEY_W-1:0] k,
		logic [HDL_W-1:0] h);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_req <= '{opcode: op, item_key: k, item_handle: h};
		forever begin
			@(posedge clk);
			if (in_ready) break;
		end
		heap_model.note_request(in_req);
		@(negedge clk);
	endtask

	// Wait until every queued result has come back, then let the core settle.
	task automatic drain();
		in_valid <= 1'b0;
		while (heap_model.pending.size() != 0) @(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	// Setup then access cycle; the register takes the value on the access edge.
	task automatic write_capacity(int unsigned value);
		psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
		paddr <= 3'(4 * REG_CAPACITY); pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		heap_model.cap = value & 11'h7FF;
	endtask

	// Key biased toward a small range so that ties and orderings occur often.
	function automatic logic signed [KEY_W-1:0] pick_key();
		case ($urandom_range(3))
			0: return $urandom;
			1: return $signed($urandom_range(16)) - 8;
			2: return $urandom_range(1) ? 32'sh7FFFFFFF : 32'sh80000000;
			default: return $signed($urandom_range(200)) <<< 16;
		endcase
	endfunction

	task automatic random_burst(int count);
		int          w;
		logic [1:0]  op;
		for (int i = 0; i < count; i++) begin
			w = $urandom_range(99);
			// mostly pushes so the heap fills up and eviction gets exercised
			op = (w < 40) ? OP_PUSH : (w < 70) ? OP_PPUSH : (w < 98) ? OP_POP : OP_CLEAR;
			send_request(op, pick_key(), 16'($urandom));
		end
	endtask

	initial begin
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: empty pop, extremes, ties, clear, full-heap eviction rules
		send_request(OP_POP, 0, 0);
		send_request(OP_PPUSH, 32'sh80000000, 16'h0000);
		send_request(OP_PUSH, 32'sh7FFFFFFF, 16'hFFFF);
		send_request(OP_PUSH, 5, 16'h1111);
		send_request(OP_PUSH, 5, 16'h2222);
		send_request(OP_PPUSH, 32'sh80000000, 16'h3333);
		send_request(OP_PPUSH, -7, 16'h4444);
		send_request(OP_POP, 0, 0);
		send_request(OP_POP, 0, 0);
		send_request(OP_CLEAR, 32'sh7FFFFFFF, 16'hFFFF);
		send_request(OP_POP, 0, 0);
		drain();
		write_capacity(3);
		send_request(OP_PUSH, 10, 1);
		send_request(OP_PUSH, 20, 2);
		send_request(OP_PUSH, 30, 3);
		send_request(OP_PUSH, 10, 4);    // equal to smallest leaf: rejected
		send_request(OP_PUSH, 11, 5);    // greater: evicts
		send_request(OP_PPUSH, 11, 6);   // equal on full heap: evicts
		send_request(OP_PPUSH, 1, 7);    // below smallest leaf: rejected
		drain();
		write_capacity(1);               // lowered below fill: counts as full
		send_request(OP_PUSH, 40, 8);
		send_request(OP_PPUSH, 0, 9);
		send_request(OP_CLEAR, 0, 0);
		drain();
		write_capacity(0);
		send_request(OP_PUSH, 1, 10);
		send_request(OP_PUSH, 2, 11);
		drain();

		send_idle_pct = 29; recv_idle_pct = 81;
		write_capacity(2047);
		random_burst(250);
		drain();                         // sender holds off until all results are in
		write_capacity(7);
		random_burst(150);
		drain();
		send_idle_pct = 81; recv_idle_pct = 29;
		write_capacity(1024);
		random_burst(300);
		drain();
		send_idle_pct = 0; recv_idle_pct = 0;
		write_capacity(33);
		random_burst(200);
		drain();
		write_capacity(2);
		random_burst(200);
		drain();

		if (heap_model.errors == 0 && heap_model.pending.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("status: fail");
		$finish;
	end

endmodule
